FILE: rtl/pida_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pida_pkg;

   // Sizes fixed by the field widths
   localparam int CAPACITY_DEFAULT = 64;
   localparam int DATA_W           = 32;
   localparam int POS_W            = 7;
   localparam int CNT_W            = 7;
   localparam int IDX_W            = 6;

   // Operation codes
   localparam logic [1:0] OP_DISPLAY = 2'd0;
   localparam logic [1:0] OP_INSERT  = 2'd1;
   localparam logic [1:0] OP_DELETE  = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_EMPTY  = 2'd2;
   localparam logic [1:0] STAT_BADPOS = 2'd3;

   // Per-cycle action of the cell chain
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   typedef struct packed {
      logic [1:0]               opcode;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] element;
      logic [IDX_W-1:0]         index;
      logic [CNT_W-1:0]         fill_count;
      logic [1:0]               status;
      logic                     last;
   } rsp_type;

   // Broadcast control to every cell
   typedef struct packed {
      logic [1:0]               cell_op;
      logic [POS_W-1:0]         pos;
      logic [CNT_W-1:0]         count;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/pida_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pida_cell
   import pida_pkg::*;
#(
   parameter int CELL_IDX = 0
) (
   input  wire logic                     clock,
   input  wire cell_ctrl_type            ctrl,
   input  wire logic signed [DATA_W-1:0] left_data,
   input  wire logic signed [DATA_W-1:0] right_data,
   input  wire logic signed [DATA_W-1:0] first_data,
   output logic signed [DATA_W-1:0]      data
);

   localparam logic [POS_W-1:0] CELL_POS = POS_W'(CELL_IDX);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   // Pick the next entry from self, neighbors, the head cell or the new value
   always_comb begin
      data_in = data_ff;
      case (ctrl.cell_op)
         CELL_INSERT: begin
            if (CELL_POS == ctrl.pos) begin
               data_in = ctrl.value;
            end else if (CELL_POS > ctrl.pos) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (CELL_POS >= ctrl.pos) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            // the head entry wraps around to the last occupied cell
            if (CELL_POS == POS_W'(ctrl.count - CNT_W'(1))) begin
               data_in = first_data;
            end else begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

FILE: rtl/positional_insert_delete_array.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered array of up to CAPACITY signed 32-bit entries held in a chain of
// cells, one entry per cell. Insert and delete shift the chain at the edge
// that takes the command, and its single result is strobed in the next
// cycle, in which a new command may also start. A display of N stored
// entries keeps busy high while the chain rotates through cell 0, strobing
// one entry per cycle, each registered from cell 0 in the display state;
// a display of an empty array gives a single empty result instead. Results
// are strobed for one cycle only; the receiver cannot stall them and must
// take each one as it appears.

module positional_insert_delete_array
   import pida_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req,
   output logic         rsp_strobe,
   output rsp_type      rsp
);

   localparam logic       ST_IDLE = 1'b0;
   localparam logic       ST_DISP = 1'b1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic             state_ff, state_in;
   logic [IDX_W-1:0] disp_idx_ff, disp_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;
   cell_ctrl_type    ctrl;
   logic             accept;
   logic             disp_last;

   logic signed [DATA_W-1:0] cell_data [CAPACITY];

   assign accept    = start && (state_ff == ST_IDLE);
   assign disp_last = (CNT_W'(disp_idx_ff) + CNT_W'(1)) == count_ff;

   // Decode the transaction and steer the chain
   always_comb begin
      state_in      = state_ff;
      disp_idx_in   = disp_idx_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      ctrl.cell_op  = CELL_HOLD;
      ctrl.pos      = req.position;
      ctrl.count    = count_ff;
      ctrl.value    = req.value;

      if (state_ff == ST_DISP) begin
         // stream cell 0 and rotate the occupied part of the chain
         rsp_strobe_in     = 1'b1;
         rsp_in.element    = cell_data[0];
         rsp_in.index      = disp_idx_ff;
         rsp_in.fill_count = count_ff;
         rsp_in.status     = STAT_OK;
         rsp_in.last       = disp_last;
         ctrl.cell_op      = CELL_ROTATE;
         disp_idx_in       = disp_idx_ff + IDX_W'(1);
         if (disp_last) begin
            state_in = ST_IDLE;
         end
      end else if (accept) begin
         rsp_strobe_in = 1'b1;
         rsp_in.last   = 1'b1;
         rsp_in.status = STAT_OK;
         case (req.opcode)
            OP_DISPLAY: begin
               if (count_ff == '0) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  rsp_strobe_in = 1'b0;
                  disp_idx_in   = '0;
                  state_in      = ST_DISP;
               end
            end
            OP_INSERT: begin
               if (count_ff >= CAP_CNT) begin
                  rsp_in.status = STAT_FULL;
               end else if (req.position > count_ff) begin
                  rsp_in.status = STAT_BADPOS;
               end else begin
                  ctrl.cell_op = CELL_INSERT;
                  count_in     = count_ff + CNT_W'(1);
               end
            end
            OP_DELETE: begin
               if (count_ff == '0) begin
                  rsp_in.status = STAT_EMPTY;
               end else if (req.position >= count_ff) begin
                  rsp_in.status = STAT_BADPOS;
               end else begin
                  ctrl.cell_op = CELL_DELETE;
                  count_in     = count_ff - CNT_W'(1);
               end
            end
            default: rsp_in.status = STAT_BADPOS;
         endcase
         rsp_in.fill_count = count_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      disp_idx_ff <= disp_idx_in;
      rsp_ff      <= rsp_in;
   end

   // Chain of entry cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_d, right_d;
      if (g == 0) begin : g_head
         assign left_d = '0;
      end else begin : g_body
         assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_d = '0;
      end else begin : g_inner
         assign right_d = cell_data[g+1];
      end
      pida_cell #(
         .CELL_IDX(g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_data  (left_d),
         .right_data (right_d),
         .first_data (cell_data[0]),
         .data       (cell_data[g])
      );
   end

   assign busy       = (state_ff == ST_DISP);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/pida_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pida_checker
   import pida_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp
);

   // A single-result command answers in the next cycle with its last result
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.opcode != OP_DISPLAY) |=> (rsp_strobe && rsp.last))
      else $error("single-result transaction not answered next cycle");

   // A display stream carries on with consecutive indices
   a_stream_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp.last) |=>
         (rsp_strobe && rsp.index == IDX_W'($past(rsp.index) + IDX_W'(1))))
      else $error("display stream broken or out of order");

   // Fill count stays within capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp.fill_count <= CNT_W'(CAPACITY)))
      else $error("fill count exceeds capacity");

   // Error results are single, with zero element and index
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.status != STAT_OK) |->
         (rsp.last && rsp.element == '0 && rsp.index == '0))
      else $error("malformed error result");

endmodule

bind positional_insert_delete_array pida_checker #(
   .CAPACITY(CAPACITY)
) u_pida_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req        (req),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);

`default_nettype wire

FILE: test/tb_positional_insert_delete_array.sv
`timescale 1ns / 1ps

module tb_positional_insert_delete_array;
   import pida_pkg::*;

   localparam int         CAPACITY    = CAPACITY_DEFAULT;
   localparam logic [1:0] OP_UNDEF    = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         RANDOM_CMDS = 292;
   localparam int         DRAIN_WAIT  = CAPACITY + 8;

   // Epoch flavors for the random part
   localparam int MODE_GROW   = 0;
   localparam int MODE_SHRINK = 1;
   localparam int MODE_MIX    = 2;

   typedef struct {
      req_type cmd;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   req_type   req;
   logic      rsp_strobe;
   rsp_type   rsp;

   // Typed expectation that travels with the command being offered
   bit        typed_now;
   rsp_type   typed_rsp_now;

   // Shadow copy of the array and the results still owed by the block
   logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
   int                       shadow_count;
   rsp_type                  awaited_rsp_q [$];

   dir_row_type dir_rows [$];
   int        fail_count;
   int        cycle_count;

   positional_insert_delete_array u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   // Apply one command to the shadow array and queue the results it owes
   task automatic compute_array_op(input req_type cmd);
      rsp_type r;
      int      i;
      r = '0;
      r.last = 1'b1;
      case (cmd.opcode)
         OP_DISPLAY: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
               awaited_rsp_q.push_back(r);
            end else begin
               for (i = 0; i < shadow_count; i++) begin
                  r.element    = shadow_entries[i];
                  r.index      = IDX_W'(i);
                  r.fill_count = CNT_W'(shadow_count);
                  r.status     = STAT_OK;
                  r.last       = (i == shadow_count - 1);
                  awaited_rsp_q.push_back(r);
               end
            end
         end
         OP_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               r.status = STAT_FULL;
            end else if (int'(cmd.position) > shadow_count) begin
               r.status = STAT_BADPOS;
            end else begin
               for (i = shadow_count; i > int'(cmd.position); i--) begin
                  shadow_entries[i] = shadow_entries[i-1];
               end
               shadow_entries[cmd.position] = cmd.value;
               shadow_count++;
               r.status = STAT_OK;
            end
            r.fill_count = CNT_W'(shadow_count);
            awaited_rsp_q.push_back(r);
         end
         OP_DELETE: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
            end else if (int'(cmd.position) >= shadow_count) begin
               r.status = STAT_BADPOS;
            end else begin
               for (i = int'(cmd.position); i + 1 < shadow_count; i++) begin
                  shadow_entries[i] = shadow_entries[i+1];
               end
               shadow_count--;
               r.status = STAT_OK;
            end
            r.fill_count = CNT_W'(shadow_count);
            awaited_rsp_q.push_back(r);
         end
         default: begin
            r.status     = STAT_BADPOS;
            r.fill_count = CNT_W'(shadow_count);
            awaited_rsp_q.push_back(r);
         end
      endcase
   endtask

   // Check each strobed result, then record any transaction taken at this edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (awaited_rsp_q.size() == 0) begin
               note_failure($sformatf("unexpected result: elem=%0d idx=%0d fill=%0d st=%0d last=%0b",
                  rsp.element, rsp.index, rsp.fill_count, rsp.status, rsp.last));
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp.element !== want.element || rsp.index !== want.index ||
                   rsp.fill_count !== want.fill_count || rsp.status !== want.status ||
                   rsp.last !== want.last) begin
                  note_failure($sformatf(
                     "mismatch: exp elem=%0d idx=%0d fill=%0d st=%0d last=%0b, got elem=%0d idx=%0d fill=%0d st=%0d last=%0b",
                     want.element, want.index, want.fill_count, want.status, want.last,
                     rsp.element, rsp.index, rsp.fill_count, rsp.status, rsp.last));
               end
            end
         end
         if (start && !busy) begin
            compute_array_op(req);
            if (typed_now) begin
               awaited_rsp_q[awaited_rsp_q.size()-1] = typed_rsp_now;
            end
         end
      end
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Mostly back-to-back, sometimes short gaps, rarely long ones
   function automatic int pick_gap(input bit no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Build a mostly well-formed command for the current fill level
   function automatic req_type random_cmd(input int mode);
      req_type cmd;
      int      r;
      int      ins_pct;
      cmd.value    = pick_value();
      cmd.position = $urandom_range(0, 127);
      r = $urandom_range(0, 99);
      ins_pct = (mode == MODE_GROW) ? 80 : (mode == MODE_SHRINK) ? 20 : 50;
      if (r < 6) begin
         cmd.opcode = OP_DISPLAY;
      end else if (r < 10) begin
         cmd.opcode = 2'($urandom_range(0, 3));
      end else if ($urandom_range(0, 99) < ins_pct) begin
         cmd.opcode = OP_INSERT;
         if (shadow_count < CAPACITY && $urandom_range(0, 19) != 0) begin
            cmd.position = POS_W'($urandom_range(0, shadow_count));
         end
      end else begin
         cmd.opcode = OP_DELETE;
         if (shadow_count > 0 && $urandom_range(0, 19) != 0) begin
            cmd.position = POS_W'($urandom_range(0, shadow_count - 1));
         end
      end
      return cmd;
   endfunction

   task automatic add_row(input logic [1:0] op, input logic [DATA_W-1:0] val,
                          input logic [POS_W-1:0] pos, input bit typed,
                          input logic [1:0] st, input int fill);
      dir_row_type row;
      row.cmd.opcode       = op;
      row.cmd.value        = val;
      row.cmd.position     = pos;
      row.typed            = typed;
      row.want             = '0;
      row.want.status      = st;
      row.want.fill_count  = CNT_W'(fill);
      row.want.last        = 1'b1;
      dir_rows.push_back(row);
   endtask

   // Offer a command at this falling edge and hold it until taken
   task automatic issue_cmd(input req_type cmd, input bit typed, input rsp_type want);
      start         <= 1'b1;
      req           <= cmd;
      typed_now     <= typed;
      typed_rsp_now <= want;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and toggle the request bits while idle
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
         req   <= {2'($urandom_range(0, 3)), 32'($urandom), 7'($urandom_range(0, 127))};
      end
   endtask

   task automatic wait_all_results();
      while (awaited_rsp_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      req_type cmd;
      int      k;
      int      load_row;
      int      sent;
      int      epoch_left;
      int      mode;
      bit      no_idle;

      start         = 1'b0;
      reset         = 1'b1;
      req           = '0;
      typed_now     = 1'b0;
      typed_rsp_now = '0;
      shadow_count  = 0;
      fail_count    = 0;
      cycle_count   = 0;

      // Error cases on an empty array, a small load with the value extremes, then bad positions and deletes
      add_row(OP_DISPLAY, 32'd0,          7'd0,   1, STAT_EMPTY,  0);
      add_row(OP_DELETE,  32'd0,          7'd0,   1, STAT_EMPTY,  0);
      add_row(OP_DELETE,  32'hffff_ffff,  7'd127, 1, STAT_EMPTY,  0);
      add_row(OP_INSERT,  32'd5,          7'd1,   1, STAT_BADPOS, 0);
      add_row(OP_INSERT,  32'd5,          7'd127, 1, STAT_BADPOS, 0);
      add_row(OP_UNDEF,   32'hffff_ffff,  7'd127, 1, STAT_BADPOS, 0);
      add_row(OP_INSERT,  32'h8000_0000,  7'd0,   1, STAT_OK,     1);
      add_row(OP_INSERT,  32'h7fff_ffff,  7'd1,   1, STAT_OK,     2);
      add_row(OP_INSERT,  32'hffff_ffff,  7'd0,   1, STAT_OK,     3);
      add_row(OP_INSERT,  32'd0,          7'd1,   1, STAT_OK,     4);
      add_row(OP_DISPLAY, 32'd0,          7'd0,   0, STAT_OK,     0);
      add_row(OP_DELETE,  32'd0,          7'd4,   1, STAT_BADPOS, 4);
      add_row(OP_DELETE,  32'd0,          7'd127, 1, STAT_BADPOS, 4);
      add_row(OP_INSERT,  32'd9,          7'd5,   1, STAT_BADPOS, 4);
      add_row(OP_DELETE,  32'd0,          7'd3,   1, STAT_OK,     3);
      add_row(OP_DELETE,  32'd0,          7'd0,   1, STAT_OK,     2);
      add_row(OP_DISPLAY, 32'd0,          7'd0,   0, STAT_OK,     0);
      add_row(OP_UNDEF,   32'd0,          7'd0,   1, STAT_BADPOS, 2);
      // Full array: full is reported ahead of a bad position
      load_row = dir_rows.size();
      add_row(OP_INSERT,  32'd1,          7'd0,   1, STAT_FULL,   CAPACITY);
      add_row(OP_INSERT,  32'd1,          7'd127, 1, STAT_FULL,   CAPACITY);
      add_row(OP_DISPLAY, 32'd0,          7'd0,   0, STAT_OK,     0);
      add_row(OP_DELETE,  32'd0,          7'(CAPACITY), 1, STAT_BADPOS, CAPACITY);
      add_row(OP_DELETE,  32'd0,          7'd127, 1, STAT_BADPOS, CAPACITY);
      add_row(OP_DELETE,  32'd0,          7'(CAPACITY - 1), 1, STAT_OK, CAPACITY - 1);
      add_row(OP_INSERT,  32'h7fff_ffff,  7'(CAPACITY - 1), 1, STAT_OK, CAPACITY);
      add_row(OP_DELETE,  32'd0,          7'd0,   1, STAT_OK,     CAPACITY - 1);

      // Hold reset, then drop it at a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table, bulk loading to full at the marked row
      for (k = 0; k < dir_rows.size(); k++) begin
         if (k == load_row) begin
            while (shadow_count < CAPACITY) begin
               @(negedge clock);
               cmd.opcode   = OP_INSERT;
               cmd.value    = pick_value();
               cmd.position = POS_W'(shadow_count);
               issue_cmd(cmd, 1'b0, '0);
               idle_cycles(pick_gap(1'b0));
            end
         end
         @(negedge clock);
         issue_cmd(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].want);
         idle_cycles(pick_gap(1'b0));
      end

      // Let the block drain before the random part
      @(negedge clock);
      start <= 1'b0;
      wait_all_results();

      // Random epochs that grow, shrink or churn the array
      sent       = 0;
      epoch_left = 0;
      mode       = MODE_MIX;
      no_idle    = 1'b0;
      while (sent < RANDOM_CMDS) begin
         if (epoch_left == 0) begin
            epoch_left = $urandom_range(20, 60);
            mode       = $urandom_range(MODE_GROW, MODE_MIX);
            no_idle    = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
               @(negedge clock);
               start <= 1'b0;
               wait_all_results();
            end
         end
         @(negedge clock);
         issue_cmd(random_cmd(mode), 1'b0, '0);
         idle_cycles(pick_gap(no_idle));
         sent++;
         epoch_left--;
      end

      // Drain and let any stray result show up
      @(negedge clock);
      start <= 1'b0;
      wait_all_results();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
